FILE: rtl/long_press_gesture_detector_unit_macros.svh
// Assertion macros shared by the long-press detector RTL.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef LONG_PRESS_GESTURE_DETECTOR_UNIT_MACROS_SVH
`define LONG_PRESS_GESTURE_DETECTOR_UNIT_MACROS_SVH

// Generic clocked assertion, disabled while reset is active.
`define LPGD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication built on the generic form.
`define LPGD_ASSERT_IMP(lbl, ante, cons, msg) \
  `LPGD_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication built on the generic form.
`define LPGD_ASSERT_NXT(lbl, ante, cons, msg) \
  `LPGD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: rtl/lpgd_pkg.sv
// Package for the long-press gesture detector: widths, codes and shared types.
// No dependencies; imported by every module of the block.
`default_nettype none

package lpgd_pkg;

  localparam int unsigned PosW    = 12;
  localparam int unsigned IdW     = 9;
  localparam int unsigned CountW  = 4;
  localparam int unsigned TicksW  = 16;
  localparam int unsigned DistW   = 25;
  localparam int unsigned SquareW = 2 * PosW;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  localparam logic [TicksW-1:0] MinPressTicksRst = TicksW'(400);
  localparam logic [DistW-1:0]  MaxSqDistanceRst = DistW'(100);
  localparam logic [TicksW-1:0] TicksMax         = '1;

  // Input opcodes.
  typedef enum logic [2:0] {
    OP_BEGIN  = 3'd0,
    OP_END    = 3'd1,
    OP_MOVE   = 3'd2,
    OP_CANCEL = 3'd3,
    OP_TICK   = 3'd4
  } op_e;

  // Recognizer phase.
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_RECOG   = 2'd1,
    PH_PRESSED = 2'd2
  } phase_e;

  // Result kinds.
  typedef enum logic [1:0] {
    EV_BEGAN   = 2'd0,
    EV_CHANGED = 2'd1,
    EV_ENDED   = 2'd2
  } event_e;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_MIN_PRESS_TICKS = 1'b0,
    REG_MAX_SQ_DISTANCE = 1'b1
  } reg_e;

  // Configuration handed from the register file to the recognizer.
  typedef struct packed {
    logic [TicksW-1:0] min_press_ticks;
    logic [DistW-1:0]  max_sq_distance;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/long_press_gesture_detector_unit.sv
// Long-press gesture detector: top level with the configuration registers.
// Depends on lpgd_pkg and lpgd_core (which uses lpgd_drift).
//
// The detector takes one touch or tick word per clock and answers with at most
// one press word (began, changed or ended) per accepted word, which passes the
// input register and then the result register. The gesture state lives between
// those two registers and is updated in a single pass, so the sustained rate is
// one word per cycle; the input only stalls when a result word waits and the
// output side holds it. The configuration registers (minimum press ticks at 0x0,
// maximum squared drift at 0x4) must be written by the user over the APB-style
// port only while no word is in flight; the block itself does not enforce this.
`default_nettype none

module long_press_gesture_detector_unit
  import lpgd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ApbAddrW-1:0]   paddr,
  input  logic [ApbDataW-1:0]   pwdata,
  output logic [ApbDataW-1:0]   prdata,
  output logic                  pready,
  // Input words.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            opcode_i,
  input  logic signed [IdW-1:0] touch_id_i,
  input  logic [CountW-1:0]     touch_count_i,
  input  logic [PosW-1:0]       x_pos_i,
  input  logic [PosW-1:0]       y_pos_i,
  // Result words.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            event_kind_o,
  output logic [PosW-1:0]       event_x_o,
  output logic [PosW-1:0]       event_y_o
);

  cfg_t cfg_q;
  reg_e reg_sel;
  logic wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes, masked to each register's width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_press_ticks <= MinPressTicksRst;
      cfg_q.max_sq_distance <= MaxSqDistanceRst;
    end else if (wr_en) begin
      case (reg_sel)
        REG_MIN_PRESS_TICKS: cfg_q.min_press_ticks <= pwdata[TicksW-1:0];
        REG_MAX_SQ_DISTANCE: cfg_q.max_sq_distance <= pwdata[DistW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register reads.
  always_comb begin
    case (reg_sel)
      REG_MIN_PRESS_TICKS: prdata = ApbDataW'(cfg_q.min_press_ticks);
      REG_MAX_SQ_DISTANCE: prdata = ApbDataW'(cfg_q.max_sq_distance);
      default:             prdata = '0;
    endcase
  end

  lpgd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .touch_id_i    (touch_id_i),
    .touch_count_i (touch_count_i),
    .x_pos_i       (x_pos_i),
    .y_pos_i       (y_pos_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .event_kind_o  (event_kind_o),
    .event_x_o     (event_x_o),
    .event_y_o     (event_y_o)
  );

endmodule

`default_nettype wire

FILE: rtl/lpgd_drift.sv
// Squared drift of the current touch position from the start position.
// Depends on lpgd_pkg for the position and distance widths.
`default_nettype none

module lpgd_drift
  import lpgd_pkg::*;
(
  input  logic [PosW-1:0]  start_x_i,
  input  logic [PosW-1:0]  start_y_i,
  input  logic [PosW-1:0]  cur_x_i,
  input  logic [PosW-1:0]  cur_y_i,
  output logic [DistW-1:0] sq_dist_o
);

  logic [PosW-1:0]    dx;
  logic [PosW-1:0]    dy;
  logic [SquareW-1:0] dx_sq;
  logic [SquareW-1:0] dy_sq;

  // Absolute differences on each axis.
  assign dx = (cur_x_i > start_x_i) ? (cur_x_i - start_x_i) : (start_x_i - cur_x_i);
  assign dy = (cur_y_i > start_y_i) ? (cur_y_i - start_y_i) : (start_y_i - cur_y_i);

  // Two 12-bit squares and their exact sum.
  assign dx_sq     = SquareW'(dx) * SquareW'(dx);
  assign dy_sq     = SquareW'(dy) * SquareW'(dy);
  assign sq_dist_o = DistW'(dx_sq) + DistW'(dy_sq);

endmodule

`default_nettype wire

FILE: rtl/lpgd_core.sv
// Recognizer core: input word register, gesture state and result word register.
// Depends on lpgd_pkg, lpgd_drift and the assertion macro header.
`default_nettype none

`include "long_press_gesture_detector_unit_macros.svh"

module lpgd_core
  import lpgd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfg_t                 cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [2:0]           opcode_i,
  input  logic signed [IdW-1:0] touch_id_i,
  input  logic [CountW-1:0]    touch_count_i,
  input  logic [PosW-1:0]      x_pos_i,
  input  logic [PosW-1:0]      y_pos_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           event_kind_o,
  output logic [PosW-1:0]      event_x_o,
  output logic [PosW-1:0]      event_y_o
);

  // Input word register.
  logic               s1_valid_q;
  logic [2:0]         s1_op_q;
  logic [IdW-1:0]     s1_id_q;
  logic [CountW-1:0]  s1_count_q;
  logic [PosW-1:0]    s1_x_q;
  logic [PosW-1:0]    s1_y_q;

  // Gesture state.
  phase_e             phase_q, phase_d;
  logic [PosW-1:0]    start_x_q, start_x_d;
  logic [PosW-1:0]    start_y_q, start_y_d;
  logic [PosW-1:0]    cur_x_q, cur_x_d;
  logic [PosW-1:0]    cur_y_q, cur_y_d;
  logic [IdW-2:0]     tracked_id_q, tracked_id_d;
  logic [TicksW-1:0]  ticks_q, ticks_d;

  // Result word register.
  logic               out_valid_q;
  event_e             out_kind_q;
  logic [PosW-1:0]    out_x_q;
  logic [PosW-1:0]    out_y_q;

  logic               out_free;
  logic               proc_go;
  logic               res_valid;
  event_e             res_kind;
  logic               id_neg;
  logic               id_match;
  logic [DistW-1:0]   sq_dist;

  // The result register can take a word when empty or when its word leaves now.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc_go    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;

  lpgd_drift u_drift (
    .start_x_i (start_x_q),
    .start_y_i (start_y_q),
    .cur_x_i   (cur_x_q),
    .cur_y_i   (cur_y_q),
    .sq_dist_o (sq_dist)
  );

  assign id_neg   = s1_id_q[IdW-1];
  assign id_match = !id_neg && (s1_id_q[IdW-2:0] == tracked_id_q);

  // Next gesture state and the result word for the registered input word.
  always_comb begin
    phase_d      = phase_q;
    start_x_d    = start_x_q;
    start_y_d    = start_y_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    tracked_id_d = tracked_id_q;
    ticks_d      = ticks_q;
    res_valid    = 1'b0;
    res_kind     = EV_ENDED;
    case (op_e'(s1_op_q))
      OP_BEGIN: begin
        if (!id_neg) begin
          start_x_d    = s1_x_q;
          start_y_d    = s1_y_q;
          cur_x_d      = s1_x_q;
          cur_y_d      = s1_y_q;
          ticks_d      = '0;
          tracked_id_d = s1_id_q[IdW-2:0];
          phase_d      = PH_RECOG;
        end
      end
      OP_END: begin
        if (phase_q != PH_IDLE) begin
          cur_x_d   = s1_x_q;
          cur_y_d   = s1_y_q;
          res_valid = (phase_q == PH_PRESSED);
          phase_d   = PH_IDLE;
        end
      end
      OP_MOVE: begin
        if (phase_q != PH_IDLE) begin
          if (s1_count_q != CountW'(1) || !id_match) begin
            // A foreign move, or one whose touch count is not one, ends the gesture where it was.
            res_valid = (phase_q == PH_PRESSED);
            phase_d   = PH_IDLE;
          end else begin
            cur_x_d   = s1_x_q;
            cur_y_d   = s1_y_q;
            res_valid = (phase_q == PH_PRESSED);
            res_kind  = EV_CHANGED;
          end
        end
      end
      OP_CANCEL: begin
        res_valid = (phase_q == PH_PRESSED);
        phase_d   = PH_IDLE;
      end
      OP_TICK: begin
        if (phase_q == PH_RECOG) begin
          if (ticks_q != TicksMax) begin
            ticks_d = ticks_q + TicksW'(1);
          end
          if (ticks_d >= cfg_i.min_press_ticks && sq_dist < cfg_i.max_sq_distance) begin
            res_valid = 1'b1;
            res_kind  = EV_BEGAN;
            phase_d   = PH_PRESSED;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Input word register: loads whenever it is not stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_op_q    <= opcode_i;
      s1_id_q    <= touch_id_i;
      s1_count_q <= touch_count_i;
      s1_x_q     <= x_pos_i;
      s1_y_q     <= y_pos_i;
    end
  end

  // Gesture state advances once per processed word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      start_x_q    <= '0;
      start_y_q    <= '0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      tracked_id_q <= '0;
      ticks_q      <= '0;
    end else if (proc_go) begin
      phase_q      <= phase_d;
      start_x_q    <= start_x_d;
      start_y_q    <= start_y_d;
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      tracked_id_q <= tracked_id_d;
      ticks_q      <= ticks_d;
    end
  end

  // Result word register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= proc_go && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_go && res_valid) begin
      out_kind_q <= res_kind;
      out_x_q    <= cur_x_d;
      out_y_q    <= cur_y_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = out_kind_q;
  assign event_x_o    = out_x_q;
  assign event_y_o    = out_y_q;

  // A changed word only comes out of a press that has begun.
  `LPGD_ASSERT_IMP(a_changed_when_pressed, proc_go && res_valid && res_kind == EV_CHANGED, phase_q == PH_PRESSED, "changed word outside a press")
  // A began word always leaves the recognizer in the pressed phase.
  `LPGD_ASSERT_NXT(a_began_to_pressed, proc_go && res_valid && res_kind == EV_BEGAN, phase_q == PH_PRESSED, "began word without entering pressed")
  // An ended word always returns the recognizer to idle.
  `LPGD_ASSERT_NXT(a_ended_to_idle, proc_go && res_valid && res_kind == EV_ENDED, phase_q == PH_IDLE, "ended word without returning to idle")
  // The input side only stalls when both registers are full and the output is held.
  `LPGD_ASSERT_IMP(a_stall_cause, in_stall_o, s1_valid_q && out_valid_q && out_stall_i, "input stalled without a full pipeline")

endmodule

`default_nettype wire
